@@ design/cgm_pkg.sv @@
`timescale 1ns / 1ps
package cgm_pkg;

  // Operand and accumulator formats: Q1.15 operands, Q18.30 accumulators
  localparam int OPW     = 16;
  localparam int ACCW    = 48;
  localparam int FRAC    = OPW - 1;
  localparam int PROD_W  = 2 * OPW;
  localparam int CPROD_W = PROD_W + 1;
  localparam int APROD_W = ACCW + OPW;
  localparam int ADIFF_W = APROD_W + 1;
  localparam int SCALE_W = ADIFF_W - FRAC;
  localparam int SUM_W   = SCALE_W + 1;
  localparam int TILE_N  = 8;
  localparam int CIDX_W  = 3;

  // Command queue depth, a power of two so the pointers wrap on their own
  localparam int QDEPTH  = 4;
  localparam int QPTR_W  = $clog2(QDEPTH);

  // Configuration register indexes
  localparam int REG_IDX_W = 1;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_RE = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_ALPHA_IM = 1'b1;

  // Operation codes of an input request
  localparam logic OP_KSTEP  = 1'b0;
  localparam logic OP_LOAD_C = 1'b1;

  typedef logic signed [OPW-1:0]  opnd_t;
  typedef logic signed [ACCW-1:0] acc_t;

  localparam opnd_t ALPHA_RE_RST = opnd_t'(32767);
  localparam opnd_t ALPHA_IM_RST = opnd_t'(0);

  typedef struct packed {
    logic                operation;
    opnd_t               a_row0_re;
    opnd_t               a_row0_im;
    opnd_t               a_row1_re;
    opnd_t               a_row1_im;
    opnd_t               b_col0_re;
    opnd_t               b_col0_im;
    opnd_t               b_col1_re;
    opnd_t               b_col1_im;
    logic                last_step;
    logic [CIDX_W-1:0]   c_index;
    acc_t                c_value;
  } in_item_t;

  typedef struct packed {
    acc_t c_r0c0_re;
    acc_t c_r0c0_im;
    acc_t c_r1c0_re;
    acc_t c_r1c0_im;
    acc_t c_r0c1_re;
    acc_t c_r0c1_im;
    acc_t c_r1c1_re;
    acc_t c_r1c1_im;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_STEP      = 2'd1,
    CMD_STEP_LAST = 2'd2
  } cmd_kind_t;

  // One classified request: a[] is {row0 re, row0 im, row1 re, row1 im}, b[] likewise by column
  typedef struct packed {
    cmd_kind_t           kind;
    opnd_t [3:0]         a;
    opnd_t [3:0]         b;
    logic [CIDX_W-1:0]   c_index;
    acc_t                c_value;
  } cmd_t;

  typedef struct packed {
    opnd_t re;
    opnd_t im;
  } alpha_t;

  // Clamp a widened sum to the accumulator range
  function automatic acc_t sat_acc(input logic signed [SUM_W-1:0] x);
    logic all_zero;
    logic all_one;
    all_zero = ~|x[SUM_W-1:ACCW-1];
    all_one  = &x[SUM_W-1:ACCW-1];
    if (all_zero || all_one) begin
      sat_acc = x[ACCW-1:0];
    end else if (x[SUM_W-1]) begin
      sat_acc = {1'b1, {(ACCW-1){1'b0}}};
    end else begin
      sat_acc = {1'b0, {(ACCW-1){1'b1}}};
    end
  endfunction

endpackage

@@ design/cgm_if.sv @@
`timescale 1ns / 1ps
interface cgm_in_if;
  logic                 valid;
  logic                 ready;
  cgm_pkg::in_item_t    data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface cgm_out_if;
  logic                 valid;
  logic                 ready;
  cgm_pkg::out_item_t   data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ design/cgm_front.sv @@
`timescale 1ns / 1ps
module cgm_front (
  input  logic                             clk,
  input  logic                             rst,
  cgm_in_if.sink                           operand,
  input  logic                             cfg_we,
  input  logic [cgm_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [cgm_pkg::OPW-1:0]          cfg_data,
  input  logic                             q_full,
  output logic                             push,
  output cgm_pkg::cmd_t                    push_cmd,
  output cgm_pkg::alpha_t                  alpha
);

  // Take a request whenever the queue has room
  assign operand.ready = !q_full;
  assign push          = operand.valid && !q_full;

  // Classify the request and pack its operands
  always_comb begin
    if (operand.data.operation == cgm_pkg::OP_LOAD_C) begin
      push_cmd.kind = cgm_pkg::CMD_LOAD;
    end else if (operand.data.last_step) begin
      push_cmd.kind = cgm_pkg::CMD_STEP_LAST;
    end else begin
      push_cmd.kind = cgm_pkg::CMD_STEP;
    end
    push_cmd.a[0]    = operand.data.a_row0_re;
    push_cmd.a[1]    = operand.data.a_row0_im;
    push_cmd.a[2]    = operand.data.a_row1_re;
    push_cmd.a[3]    = operand.data.a_row1_im;
    push_cmd.b[0]    = operand.data.b_col0_re;
    push_cmd.b[1]    = operand.data.b_col0_im;
    push_cmd.b[2]    = operand.data.b_col1_re;
    push_cmd.b[3]    = operand.data.b_col1_im;
    push_cmd.c_index = operand.data.c_index;
    push_cmd.c_value = operand.data.c_value;
  end

  // Hold the alpha scale registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alpha.re <= cgm_pkg::ALPHA_RE_RST;
      alpha.im <= cgm_pkg::ALPHA_IM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cgm_pkg::REG_ALPHA_RE: alpha.re <= cfg_data;
        cgm_pkg::REG_ALPHA_IM: alpha.im <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

@@ design/cgm_cmd_queue.sv @@
`timescale 1ns / 1ps
module cgm_cmd_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  cgm_pkg::cmd_t   push_cmd,
  output logic            full,
  input  logic            pop,
  output cgm_pkg::cmd_t   head,
  output logic            empty
);

  cgm_pkg::cmd_t                 slots [cgm_pkg::QDEPTH];
  logic [cgm_pkg::QPTR_W-1:0]    wr_ptr;
  logic [cgm_pkg::QPTR_W-1:0]    rd_ptr;
  logic [cgm_pkg::QPTR_W:0]      count;

  assign full  = count == (cgm_pkg::QPTR_W+1)'(cgm_pkg::QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store the pushed request
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command queue pushed while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command queue popped while empty");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 1'b1)
    else $error("command queue count did not advance on push");

endmodule

@@ design/cgm_back.sv @@
`timescale 1ns / 1ps
module cgm_back (
  input  logic              clk,
  input  logic              rst,
  input  cgm_pkg::alpha_t   alpha,
  input  cgm_pkg::cmd_t     head,
  input  logic              q_empty,
  output logic              pop,
  cgm_out_if.source         result
);

  typedef enum logic [3:0] {
    ST_RUN  = 4'b0001,
    ST_MUL  = 4'b0010,
    ST_ADD  = 4'b0100,
    ST_EMIT = 4'b1000
  } back_state_t;

  back_state_t                          state;
  logic [1:0]                           cnt;
  logic                                 s1_valid;
  logic                                 s1_last;
  logic signed [cgm_pkg::CPROD_W-1:0]   s1_prod      [cgm_pkg::TILE_N];
  logic signed [cgm_pkg::CPROD_W-1:0]   s1_prod_next [cgm_pkg::TILE_N];
  cgm_pkg::acc_t                        acc          [cgm_pkg::TILE_N];
  cgm_pkg::acc_t                        acc_next     [cgm_pkg::TILE_N];
  cgm_pkg::acc_t                        tile         [cgm_pkg::TILE_N];
  logic signed [cgm_pkg::APROD_W-1:0]   p_rr;
  logic signed [cgm_pkg::APROD_W-1:0]   p_ii;
  logic signed [cgm_pkg::APROD_W-1:0]   p_ir;
  logic signed [cgm_pkg::APROD_W-1:0]   p_ri;
  logic signed [cgm_pkg::ADIFF_W-1:0]   diff_re;
  logic signed [cgm_pkg::ADIFF_W-1:0]   diff_im;
  cgm_pkg::acc_t                        new_re;
  cgm_pkg::acc_t                        new_im;
  logic                                 out_valid;
  cgm_pkg::out_item_t                   out_data;

  // Hold the queue while a last step drains or the alpha pass runs
  assign pop = (state == ST_RUN) && !q_empty && !(s1_valid && s1_last);

  // Complex outer product of the head request: word k = 4*col + 2*row (+1 imaginary)
  always_comb begin
    logic signed [cgm_pkg::PROD_W-1:0] rr, ii, ir, ri;
    for (int col = 0; col < 2; col++) begin
      for (int row = 0; row < 2; row++) begin
        rr = $signed(head.a[2*row])     * $signed(head.b[2*col]);
        ii = $signed(head.a[2*row + 1]) * $signed(head.b[2*col + 1]);
        ir = $signed(head.a[2*row + 1]) * $signed(head.b[2*col]);
        ri = $signed(head.a[2*row])     * $signed(head.b[2*col + 1]);
        s1_prod_next[4*col + 2*row]     = cgm_pkg::CPROD_W'(rr) - cgm_pkg::CPROD_W'(ii);
        s1_prod_next[4*col + 2*row + 1] = cgm_pkg::CPROD_W'(ir) + cgm_pkg::CPROD_W'(ri);
      end
    end
  end

  // Saturating accumulate of the registered products
  always_comb begin
    for (int k = 0; k < cgm_pkg::TILE_N; k++) begin
      acc_next[k] = cgm_pkg::sat_acc(cgm_pkg::SUM_W'(acc[k]) + cgm_pkg::SUM_W'(s1_prod[k]));
    end
  end

  // Alpha scaling of the pair at the bottom of the rotating tile, floor by 2^FRAC
  always_comb begin
    diff_re = cgm_pkg::ADIFF_W'(p_rr) - cgm_pkg::ADIFF_W'(p_ii);
    diff_im = cgm_pkg::ADIFF_W'(p_ir) + cgm_pkg::ADIFF_W'(p_ri);
    new_re  = cgm_pkg::sat_acc(cgm_pkg::SUM_W'(tile[0])
              + cgm_pkg::SUM_W'($signed(diff_re[cgm_pkg::ADIFF_W-1:cgm_pkg::FRAC])));
    new_im  = cgm_pkg::sat_acc(cgm_pkg::SUM_W'(tile[1])
              + cgm_pkg::SUM_W'($signed(diff_im[cgm_pkg::ADIFF_W-1:cgm_pkg::FRAC])));
  end

  // Control, accumulators and C tile
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      cnt       <= '0;
      s1_valid  <= 1'b0;
      s1_last   <= 1'b0;
      out_valid <= 1'b0;
      for (int k = 0; k < cgm_pkg::TILE_N; k++) begin
        acc[k]  <= '0;
        tile[k] <= '0;
      end
    end else begin
      s1_valid <= pop && (head.kind != cgm_pkg::CMD_LOAD);
      s1_last  <= head.kind == cgm_pkg::CMD_STEP_LAST;
      if (pop && head.kind == cgm_pkg::CMD_LOAD) tile[head.c_index] <= head.c_value;
      // Load a new tile into the output register, or drop the taken one
      if (state == ST_EMIT && (!out_valid || result.ready)) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_RUN: begin
          if (s1_valid) begin
            acc <= acc_next;
            if (s1_last) begin
              state <= ST_MUL;
              cnt   <= '0;
            end
          end
        end
        ST_MUL: begin
          // Shift the accumulators down a pair; zeros fill from the top
          for (int k = 0; k < cgm_pkg::TILE_N - 2; k++) acc[k] <= acc[k + 2];
          acc[cgm_pkg::TILE_N-2] <= '0;
          acc[cgm_pkg::TILE_N-1] <= '0;
          state <= ST_ADD;
        end
        ST_ADD: begin
          // Rotate the tile a pair; four passes restore word order
          for (int k = 0; k < cgm_pkg::TILE_N - 2; k++) tile[k] <= tile[k + 2];
          tile[cgm_pkg::TILE_N-2] <= new_re;
          tile[cgm_pkg::TILE_N-1] <= new_im;
          cnt   <= cnt + 1'b1;
          state <= (cnt == 2'd3) ? ST_EMIT : ST_MUL;
        end
        ST_EMIT: begin
          if (!out_valid || result.ready) begin
            state <= ST_RUN;
          end
        end
        default: state <= ST_RUN;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    s1_prod <= s1_prod_next;
    if (state == ST_MUL) begin
      p_rr <= $signed(acc[0]) * $signed(alpha.re);
      p_ii <= $signed(acc[1]) * $signed(alpha.im);
      p_ir <= $signed(acc[1]) * $signed(alpha.re);
      p_ri <= $signed(acc[0]) * $signed(alpha.im);
    end
    if (state == ST_EMIT && (!out_valid || result.ready)) begin
      out_data.c_r0c0_re <= tile[0];
      out_data.c_r0c0_im <= tile[1];
      out_data.c_r1c0_re <= tile[2];
      out_data.c_r1c0_im <= tile[3];
      out_data.c_r0c1_re <= tile[4];
      out_data.c_r0c1_im <= tile[5];
      out_data.c_r1c1_re <= tile[6];
      out_data.c_r1c1_im <= tile[7];
    end
  end

  assign result.valid = out_valid;
  assign result.data  = out_data;

  a_last_enters_alpha: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN && s1_valid && s1_last) |=> state == ST_MUL)
    else $error("last step did not start the alpha pass");
  a_emit_after_four: assert property (@(posedge clk) disable iff (rst)
    $rose(state == ST_EMIT) |-> $past(cnt) == 2'd3)
    else $error("tile emitted before all four pairs were scaled");
  a_emit_acc_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT) |-> (acc[0] == '0 && acc[3] == '0 && acc[6] == '0 && acc[7] == '0))
    else $error("accumulators not cleared at emit");
  a_hold_in_alpha: assert property (@(posedge clk) disable iff (rst)
    (state != ST_RUN) |-> !pop)
    else $error("request taken during the alpha pass");

endmodule

@@ design/complex_gemm_tile_mac_unit.sv @@
`timescale 1ns / 1ps
// Channel    Kind     Handshake        Carries
// operand    sink     valid / ready    k-step operands or one C word load
// result     source   valid / ready    updated 2x2 complex C tile (8 words)
// cfg        write    cfg_we           alpha_re (index 0), alpha_im (index 1)
//
// A load or non-final k-step does not hold the back end; k-steps stream at one per cycle while
// no final k-step is in progress. A final k-step holds it through the product stage,
// accumulate, four pairs of 48x16 multiply and add steps on one shared scaling unit, and emit.
// A 4-entry request queue lets the input keep flowing while the back end scales or stalls.
// Reset (rst, synchronous) clears accumulators and C tile, sets alpha to 32767 + 0i.
// A stalled result holds the back end in its emit step; the queue then fills and drops ready.
module complex_gemm_tile_mac_unit (
  input  logic                            clk,
  input  logic                            rst,
  cgm_in_if.sink                          operand,
  cgm_out_if.source                       result,
  input  logic                            cfg_we,
  input  logic [cgm_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [cgm_pkg::OPW-1:0]         cfg_data
);

  logic             push;
  cgm_pkg::cmd_t    push_cmd;
  logic             q_full;
  logic             q_empty;
  logic             pop;
  cgm_pkg::cmd_t    head;
  cgm_pkg::alpha_t  alpha;

  cgm_front u_front (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .push      (push),
    .push_cmd  (push_cmd),
    .alpha     (alpha)
  );

  cgm_cmd_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  cgm_back u_back (
    .clk     (clk),
    .rst     (rst),
    .alpha   (alpha),
    .head    (head),
    .q_empty (q_empty),
    .pop     (pop),
    .result  (result)
  );

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;

  localparam int            DRAIN_CYCLES = 40;
  localparam int            LONG_STEPS   = 64;
  localparam cgm_pkg::acc_t ACC_MAX      = {1'b0, {(cgm_pkg::ACCW-1){1'b1}}};
  localparam cgm_pkg::acc_t ACC_MIN      = ~ACC_MAX;
  localparam cgm_pkg::opnd_t OPND_MAX    = cgm_pkg::opnd_t'(32767);
  localparam cgm_pkg::opnd_t OPND_MIN    = cgm_pkg::opnd_t'(-32768);

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  logic [cgm_pkg::REG_IDX_W-1:0] cfg_index;
  logic [cgm_pkg::OPW-1:0]       cfg_data;

  cgm_in_if  operand ();
  cgm_out_if result ();

  complex_gemm_tile_mac_unit DUT (
    .clk       (clk),
    .rst       (rst),
    .operand   (operand),
    .result    (result),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  cgm_pkg::in_item_t  pending_requests[$];
  cgm_pkg::out_item_t expected_tiles[$];
  int                 send_idle_pct;
  int                 recv_idle_pct;
  int                 error_count;

  // Shadow copy of the tile state and the complex scale
  cgm_pkg::acc_t  accum [cgm_pkg::TILE_N];
  cgm_pkg::acc_t  c_words [cgm_pkg::TILE_N];
  cgm_pkg::opnd_t alpha_re_q;
  cgm_pkg::opnd_t alpha_im_q;

  string word_name [cgm_pkg::TILE_N] = '{"c_r0c0_re", "c_r0c0_im", "c_r1c0_re", "c_r1c0_im",
                                         "c_r0c1_re", "c_r0c1_im", "c_r1c1_re", "c_r1c1_im"};

  always #4 clk = ~clk;

  // Clamp a wide signed value to the accumulator range
  function automatic cgm_pkg::acc_t clamp_acc(logic signed [79:0] x);
    logic signed [79:0] hi;
    logic signed [79:0] lo;
    hi = ACC_MAX;
    lo = ACC_MIN;
    if (x > hi) return ACC_MAX;
    if (x < lo) return ACC_MIN;
    return x[cgm_pkg::ACCW-1:0];
  endfunction

  // Update the shadow tile for one accepted request; queue the tile on a final k-step
  function automatic void advance_tile_state(cgm_pkg::in_item_t r);
    cgm_pkg::opnd_t     a [4];
    cgm_pkg::opnd_t     b [4];
    cgm_pkg::opnd_t     ar, ai, br, bi;
    logic signed [79:0] xr, xi, sum;
    int                 k;
    if (r.operation == cgm_pkg::OP_LOAD_C) begin
      c_words[r.c_index] = r.c_value;
      return;
    end
    a = '{r.a_row0_re, r.a_row0_im, r.a_row1_re, r.a_row1_im};
    b = '{r.b_col0_re, r.b_col0_im, r.b_col1_re, r.b_col1_im};
    for (int col = 0; col < 2; col++) begin
      for (int row = 0; row < 2; row++) begin
        k  = 4 * col + 2 * row;
        ar = a[2*row];
        ai = a[2*row+1];
        br = b[2*col];
        bi = b[2*col+1];
        sum = accum[k];
        sum = sum + ar * br - ai * bi;
        accum[k] = clamp_acc(sum);
        sum = accum[k+1];
        sum = sum + ai * br + ar * bi;
        accum[k+1] = clamp_acc(sum);
      end
    end
    if (!r.last_step) return;
    // Scale by alpha with floor rounding, then add into C
    for (int i = 0; i < cgm_pkg::TILE_N; i += 2) begin
      xr = accum[i];
      xi = accum[i+1];
      sum = (xr * alpha_re_q - xi * alpha_im_q) >>> cgm_pkg::FRAC;
      sum = sum + c_words[i];
      c_words[i] = clamp_acc(sum);
      sum = (xi * alpha_re_q + xr * alpha_im_q) >>> cgm_pkg::FRAC;
      sum = sum + c_words[i+1];
      c_words[i+1] = clamp_acc(sum);
    end
    expected_tiles.push_back(cgm_pkg::out_item_t'({c_words[0], c_words[1], c_words[2],
                                                   c_words[3], c_words[4], c_words[5],
                                                   c_words[6], c_words[7]}));
    foreach (accum[j]) accum[j] = '0;
  endfunction

  function automatic cgm_pkg::opnd_t rand_opnd();
    case ($urandom_range(7))
      0:       return OPND_MIN;
      1:       return OPND_MAX;
      2:       return cgm_pkg::opnd_t'(-1);
      default: return cgm_pkg::opnd_t'($urandom);
    endcase
  endfunction

  function automatic cgm_pkg::acc_t rand_cword();
    case ($urandom_range(7))
      0:       return ACC_MAX;
      1:       return ACC_MIN;
      2:       return ACC_MAX - cgm_pkg::acc_t'($urandom_range(0, 1 << 24));
      3:       return ACC_MIN + cgm_pkg::acc_t'($urandom_range(0, 1 << 24));
      default: return cgm_pkg::acc_t'({$urandom, $urandom});
    endcase
  endfunction

  // Every field random, ignored ones included
  function automatic cgm_pkg::in_item_t rand_request();
    cgm_pkg::in_item_t r;
    r.operation = 1'($urandom_range(1));
    r.a_row0_re = rand_opnd();
    r.a_row0_im = rand_opnd();
    r.a_row1_re = rand_opnd();
    r.a_row1_im = rand_opnd();
    r.b_col0_re = rand_opnd();
    r.b_col0_im = rand_opnd();
    r.b_col1_re = rand_opnd();
    r.b_col1_im = rand_opnd();
    r.last_step = 1'($urandom_range(1));
    r.c_index   = cgm_pkg::CIDX_W'($urandom_range(7));
    r.c_value   = rand_cword();
    return r;
  endfunction

  function automatic cgm_pkg::in_item_t kstep_request(logic last);
    cgm_pkg::in_item_t r;
    r = rand_request();
    r.operation = cgm_pkg::OP_KSTEP;
    r.last_step = last;
    return r;
  endfunction

  function automatic cgm_pkg::in_item_t load_request(int idx, cgm_pkg::acc_t value);
    cgm_pkg::in_item_t r;
    r = rand_request();
    r.operation = cgm_pkg::OP_LOAD_C;
    r.c_index   = cgm_pkg::CIDX_W'(idx);
    r.c_value   = value;
    return r;
  endfunction

  function automatic cgm_pkg::in_item_t uniform_step(cgm_pkg::opnd_t v, logic last);
    cgm_pkg::in_item_t r;
    r = kstep_request(last);
    r.a_row0_re = v;
    r.a_row0_im = v;
    r.a_row1_re = v;
    r.a_row1_im = v;
    r.b_col0_re = v;
    r.b_col0_im = v;
    r.b_col1_re = v;
    r.b_col1_im = v;
    return r;
  endfunction

  // Mostly well-formed tiles (C loads, k-steps, final step); the rest random noise
  task automatic queue_random_tiles(int n_items);
    int queued = 0;
    int n;
    while (queued < n_items) begin
      if ($urandom_range(99) < 85) begin
        n = $urandom_range(8);
        repeat (n) pending_requests.push_back(load_request($urandom_range(7), rand_cword()));
        queued += n;
        n = $urandom_range(1, 6);
        for (int s = 1; s <= n; s++) pending_requests.push_back(kstep_request(s == n));
        queued += n;
      end else begin
        n = $urandom_range(1, 3);
        repeat (n) pending_requests.push_back(rand_request());
        queued += n;
      end
    end
  endtask

  // Wait until every request is taken and every tile is back, then let the back end settle
  task automatic wait_tile_idle();
    do @(posedge clk);
    while (pending_requests.size() != 0 || operand.valid || expected_tiles.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_alpha(int re, int im);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= cgm_pkg::REG_ALPHA_RE;
    cfg_data  <= cgm_pkg::OPW'(re);
    @(posedge clk);
    cfg_index <= cgm_pkg::REG_ALPHA_IM;
    cfg_data  <= cgm_pkg::OPW'(im);
    @(posedge clk);
    cfg_we    <= 1'b0;
    alpha_re_q = cgm_pkg::opnd_t'(re);
    alpha_im_q = cgm_pkg::opnd_t'(im);
  endtask

  // Present requests; hold the current one until it is taken
  always @(posedge clk) begin
    if (rst) begin
      operand.valid <= 1'b0;
    end else if (!operand.valid || operand.ready) begin
      if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        operand.valid <= 1'b1;
        operand.data  <= pending_requests.pop_front();
      end else begin
        operand.valid <= 1'b0;
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
    end else begin
      result.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Predict on each accepted request, check each accepted tile word by word
  always @(posedge clk) begin
    cgm_pkg::out_item_t                          tile_exp;
    logic [cgm_pkg::TILE_N*cgm_pkg::ACCW-1:0]    exp_flat;
    logic [cgm_pkg::TILE_N*cgm_pkg::ACCW-1:0]    got_flat;
    cgm_pkg::acc_t                               exp_word;
    cgm_pkg::acc_t                               got_word;
    if (!rst) begin
      if (operand.valid && operand.ready) advance_tile_state(operand.data);
      if (result.valid && result.ready) begin
        if (expected_tiles.size() == 0) begin
          $error("result tile with no request pending");
          error_count++;
        end else begin
          tile_exp = expected_tiles.pop_front();
          exp_flat = tile_exp;
          got_flat = result.data;
          for (int i = 0; i < cgm_pkg::TILE_N; i++) begin
            exp_word = exp_flat[(cgm_pkg::TILE_N-1-i)*cgm_pkg::ACCW +: cgm_pkg::ACCW];
            got_word = got_flat[(cgm_pkg::TILE_N-1-i)*cgm_pkg::ACCW +: cgm_pkg::ACCW];
            if (exp_word !== got_word) begin
              $error("%s: expected %0d, actual %0d", word_name[i], exp_word, got_word);
              error_count++;
            end
          end
        end
      end
    end
  end

  initial begin
    cgm_pkg::in_item_t r;
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_index     = cgm_pkg::REG_ALPHA_RE;
    cfg_data      = '0;
    operand.valid = 1'b0;
    operand.data  = '0;
    result.ready  = 1'b0;
    error_count   = 0;
    send_idle_pct = 22;
    recv_idle_pct = 78;
    foreach (accum[j]) begin
      accum[j]   = '0;
      c_words[j] = '0;
    end
    alpha_re_q = cgm_pkg::ALPHA_RE_RST;
    alpha_im_q = cgm_pkg::ALPHA_IM_RST;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: extreme C words, extreme operands, an empty final step
    for (int i = 0; i < cgm_pkg::TILE_N; i++) begin
      pending_requests.push_back(load_request(i, (i == 6) ? cgm_pkg::acc_t'(0) :
                                                 (i == 7) ? cgm_pkg::acc_t'(-1) :
                                                 (i % 2) ? ACC_MIN : ACC_MAX));
    end
    pending_requests.push_back(uniform_step(OPND_MIN, 1'b0));
    pending_requests.push_back(uniform_step(OPND_MAX, 1'b0));
    pending_requests.push_back(uniform_step(OPND_MIN, 1'b1));
    pending_requests.push_back(uniform_step(cgm_pkg::opnd_t'(0), 1'b1));
    r = load_request(5, ACC_MAX);
    r.last_step = 1'b1;
    pending_requests.push_back(r);
    pending_requests.push_back(kstep_request(1'b0));
    pending_requests.push_back(kstep_request(1'b1));
    queue_random_tiles(150);
    wait_tile_idle();

    write_alpha(-32768, -32768);
    queue_random_tiles(200);
    wait_tile_idle();

    send_idle_pct = 78;
    recv_idle_pct = 22;
    write_alpha(32767, 32767);
    queue_random_tiles(200);
    wait_tile_idle();

    write_alpha(-32768, 32767);
    queue_random_tiles(200);
    wait_tile_idle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_alpha($urandom, $urandom);
    queue_random_tiles(150);
    wait_tile_idle();

    // Long tile of full-scale operands to build large accumulator values
    write_alpha(32767, -32768);
    for (int s = 0; s < LONG_STEPS; s++) begin
      r = kstep_request(s == LONG_STEPS - 1);
      r.a_row0_re = OPND_MIN;
      r.a_row0_im = OPND_MIN;
      r.a_row1_re = OPND_MAX;
      r.a_row1_im = OPND_MAX;
      r.b_col0_re = OPND_MIN;
      r.b_col0_im = OPND_MAX;
      r.b_col1_re = OPND_MAX;
      r.b_col1_im = OPND_MIN;
      pending_requests.push_back(r);
    end
    queue_random_tiles(30);
    wait_tile_idle();

    if (error_count == 0) begin
      $display("complex_gemm_tile_mac_unit verification clean");
    end else begin
      $display("complex_gemm_tile_mac_unit verification failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("complex_gemm_tile_mac_unit verification failed");
    $finish;
  end

endmodule
